[src/ncor_pkg.sv]
// Shared types and constants for the neighbor cache with oldest-entry replacement.
// Depends on nothing; every other file in src uses it by scoped names.
`default_nettype none

package ncor_pkg;

	// Cache geometry
	localparam int NUM_ENTRIES = 8;
	localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int SLOT_W      = 3;

	// Field widths
	localparam int IP_W   = 64;
	localparam int LINK_W = 48;
	localparam int TICK_W = 32;

	// Tick values
	localparam logic [TICK_W-1:0] TICK_MAX  = 32'hFFFF_FFFF;
	localparam logic [TICK_W-1:0] TICK_FREE = '0;
	localparam logic [TICK_W-1:0] TICK_ONE  = 32'd1;

	// Request kinds
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// Request word
	typedef struct packed {
		logic              kind;
		logic [IP_W-1:0]   ip_high;
		logic [IP_W-1:0]   ip_low;
		logic [LINK_W-1:0] link_address;
		logic [TICK_W-1:0] now_tick;
	} req_word_t;

	// Response word
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [LINK_W-1:0] found_link_address;
	} rsp_word_t;

endpackage

`default_nettype wire

[src/ncor_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on ncor_pkg for the word types.
`default_nettype none

interface ncor_req_if;
	logic                 valid;
	logic                 ready;
	ncor_pkg::req_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ncor_rsp_if;
	logic                 valid;
	logic                 ready;
	ncor_pkg::rsp_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/neighbor_cache_oldest_replace.sv]
// Top level of the neighbor cache: entry storage, scan sequencer and response register.
// Depends on ncor_pkg and the channel interfaces in ncor_if.sv.
`default_nettype none

// Neighbor cache of ncor_pkg::NUM_ENTRIES entries, each an IPv6 address, a link
// address and an insertion tick (tick zero means free). A request word is taken
// only while the sequencer is idle; it then walks the entries one per cycle
// through a single address/tick compare path. A lookup stops at the first valid
// match; an add stops at the first free or matching entry, else picks the oldest
// tick (lowest index on ties), and then writes the entry in a write state. A word
// passes through accept, scan, the write state on an add and a load of the
// response, which waits until the response register is free. The response sits in
// an output register, so a new request is accepted while it waits to be taken.
// Reset frees all entries at once.
module neighbor_cache_oldest_replace (
	input  wire           clk,
	input  wire           arst_n,
	ncor_req_if.sink      req,
	ncor_rsp_if.source    rsp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam int IDX_W  = ncor_pkg::IDX_W;
	localparam int IP_W   = ncor_pkg::IP_W;
	localparam int LINK_W = ncor_pkg::LINK_W;
	localparam int TICK_W = ncor_pkg::TICK_W;

	// Entry storage
	logic [TICK_W-1:0] tick_q    [ncor_pkg::NUM_ENTRIES];
	logic [IP_W-1:0]   ip_high_q [ncor_pkg::NUM_ENTRIES];
	logic [IP_W-1:0]   ip_low_q  [ncor_pkg::NUM_ENTRIES];
	logic [LINK_W-1:0] link_q    [ncor_pkg::NUM_ENTRIES];

	// Sequencer state
	logic [1:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    pos_q;
	logic                hit_q;
	logic [TICK_W-1:0]   oldest_q;
	logic [LINK_W-1:0]   found_q;
	ncor_pkg::req_word_t req_q;

	// Response register
	logic                rsp_valid_q;
	ncor_pkg::rsp_word_t rsp_data_q;

	// Shared compare path on the entry under the scan index
	logic [TICK_W-1:0] cur_tick;
	logic              cur_free;
	logic              cur_same;
	logic              cur_older;
	logic              last_idx;
	logic [TICK_W-1:0] new_tick;
	logic              req_fire;
	logic              rsp_free;
	logic [IDX_W+ncor_pkg::SLOT_W-1:0] pos_ext;

	assign cur_tick  = tick_q[idx_q];
	assign cur_free  = (cur_tick == ncor_pkg::TICK_FREE);
	assign cur_same  = (ip_high_q[idx_q] == req_q.ip_high) && (ip_low_q[idx_q] == req_q.ip_low);
	assign cur_older = (cur_tick < oldest_q);
	assign last_idx  = (idx_q == IDX_W'(ncor_pkg::NUM_ENTRIES - 1));
	assign new_tick  = (req_q.now_tick == ncor_pkg::TICK_FREE) ? ncor_pkg::TICK_ONE
	                                                            : req_q.now_tick;
	assign pos_ext   = {{ncor_pkg::SLOT_W{1'b0}}, pos_q};

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Hold the accepted request word
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req.data;
		end
	end

	// Advance the sequencer and track the scan result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			pos_q    <= '0;
			hit_q    <= 1'b0;
			oldest_q <= ncor_pkg::TICK_MAX;
			found_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q  <= ST_SCAN;
						idx_q    <= '0;
						pos_q    <= '0;
						hit_q    <= 1'b0;
						oldest_q <= ncor_pkg::TICK_MAX;
						found_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (req_q.kind == ncor_pkg::KIND_LOOKUP) begin
						if (!cur_free && cur_same) begin
							hit_q   <= 1'b1;
							pos_q   <= idx_q;
							found_q <= link_q[idx_q];
							state_q <= ST_DONE;
						end else if (last_idx) begin
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end else begin
						if (cur_free) begin
							pos_q   <= idx_q;
							state_q <= ST_WRITE;
						end else if (cur_same) begin
							pos_q   <= idx_q;
							hit_q   <= 1'b1;
							state_q <= ST_WRITE;
						end else begin
							if (cur_older) begin
								oldest_q <= cur_tick;
								pos_q    <= idx_q;
							end
							if (last_idx) begin
								state_q <= ST_WRITE;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Write the tick of the chosen entry; reset frees every entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ncor_pkg::NUM_ENTRIES; i++) begin
				tick_q[i] <= ncor_pkg::TICK_FREE;
			end
		end else if (state_q == ST_WRITE) begin
			tick_q[pos_q] <= new_tick;
		end
	end

	// Write address and link of the chosen entry
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			ip_high_q[pos_q] <= req_q.ip_high;
			ip_low_q[pos_q]  <= req_q.ip_low;
			link_q[pos_q]    <= req_q.link_address;
		end
	end

	// Load the response word and drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_data_q.hit                <= hit_q;
			rsp_data_q.slot               <= pos_ext[ncor_pkg::SLOT_W-1:0];
			rsp_data_q.found_link_address <= found_q;
		end
	end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for neighbor_cache_oldest_replace: directed and random add/lookup words.
// Depends on ncor_pkg, the channel interfaces in ncor_if.sv and the block's top level.
`default_nettype none

module tb_top;
	import ncor_pkg::*;

	localparam int N_RANDOM      = 1500;
	localparam int POOL_SIZE     = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_IDLE      = 14;

	// Mirror of the cache contents; predicts one response word per request word
	class ncor_cache_scoreboard;
		logic [TICK_W-1:0] tick_of [NUM_ENTRIES];
		logic [IP_W-1:0]   hi_of   [NUM_ENTRIES];
		logic [IP_W-1:0]   lo_of   [NUM_ENTRIES];
		logic [LINK_W-1:0] link_of [NUM_ENTRIES];
		rsp_word_t         expected_rsp [$];
		int                errors;

		function new();
			foreach (tick_of[i]) begin
				tick_of[i] = TICK_FREE;
				hi_of[i]   = '0;
				lo_of[i]   = '0;
				link_of[i] = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// Scan the entries the way the block does and update the mirror on an add
		function void note_request(req_word_t w);
			rsp_word_t         r;
			int                pos;
			bit                done;
			logic [TICK_W-1:0] oldest;
			r      = '0;
			pos    = 0;
			done   = 1'b0;
			oldest = TICK_MAX;
			if (w.kind == KIND_LOOKUP) begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (!done && tick_of[i] != TICK_FREE &&
					    hi_of[i] == w.ip_high && lo_of[i] == w.ip_low) begin
						done                 = 1'b1;
						pos                  = i;
						r.hit                = 1'b1;
						r.found_link_address = link_of[i];
					end
				end
			end else begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (!done) begin
						if (tick_of[i] == TICK_FREE) begin
							pos  = i;
							done = 1'b1;
						end else if (hi_of[i] == w.ip_high && lo_of[i] == w.ip_low) begin
							pos   = i;
							r.hit = 1'b1;
							done  = 1'b1;
						end else if (tick_of[i] < oldest) begin
							oldest = tick_of[i];
							pos    = i;
						end
					end
				end
				// a zero tick would read as free, so it is stamped as one
				tick_of[pos] = (w.now_tick == TICK_FREE) ? TICK_ONE : w.now_tick;
				hi_of[pos]   = w.ip_high;
				lo_of[pos]   = w.ip_low;
				link_of[pos] = w.link_address;
			end
			r.slot = pos[SLOT_W-1:0];
			expected_rsp.push_back(r);
		endfunction

		// Compare a taken response word with the oldest prediction
		function void check_response(rsp_word_t got);
			rsp_word_t exp_rsp;
			if (expected_rsp.size() == 0) begin
				$error("unexpected response word: hit %0d slot %0d link %h",
				       got.hit, got.slot, got.found_link_address);
				errors++;
				return;
			end
			exp_rsp = expected_rsp.pop_front();
			if (got.hit !== exp_rsp.hit) begin
				$error("hit: expected %0d, actual %0d", exp_rsp.hit, got.hit);
				errors++;
			end
			if (got.slot !== exp_rsp.slot) begin
				$error("slot: expected %0d, actual %0d", exp_rsp.slot, got.slot);
				errors++;
			end
			if (got.found_link_address !== exp_rsp.found_link_address) begin
				$error("found_link_address: expected %h, actual %h",
				       exp_rsp.found_link_address, got.found_link_address);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ncor_req_if req_ch ();
	ncor_rsp_if rsp_ch ();

	neighbor_cache_oldest_replace DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ncor_cache_scoreboard cache_sb;

	bit                hold_rsp_req;
	int                send_quiet;
	int                rsp_quiet;
	logic [TICK_W-1:0] tick_clock;
	logic [IP_W-1:0]   pool_hi [POOL_SIZE];
	logic [IP_W-1:0]   pool_lo [POOL_SIZE];

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("neighbor_cache_oldest_replace regression: fail");
		$finish;
	end

	function automatic req_word_t make_word(logic kind, logic [IP_W-1:0] hi,
	                                        logic [IP_W-1:0] lo, logic [LINK_W-1:0] link,
	                                        logic [TICK_W-1:0] tick);
		req_word_t w;
		w.kind         = kind;
		w.ip_high      = hi;
		w.ip_low       = lo;
		w.link_address = link;
		w.now_tick     = tick;
		return w;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly slowly rising ticks with ties, plus zero, maximum and wild values
	function automatic logic [TICK_W-1:0] next_tick();
		case ($urandom_range(0, 31))
			0:       return TICK_FREE;
			1:       return TICK_MAX;
			2, 3:    return $urandom;
			default: begin
				tick_clock = tick_clock + $urandom_range(0, 3);
				return tick_clock;
			end
		endcase
	endfunction

	// Addresses come mostly from a small pool, so adds refresh and lookups hit
	function automatic req_word_t random_word();
		req_word_t   w;
		int          p;
		logic [63:0] link_bits;
		p = $urandom_range(0, POOL_SIZE - 1);
		if ($urandom_range(0, 19) == 0) begin
			if ($urandom_range(0, 1))
				pool_hi[p] = rand64();
			else
				pool_lo[p] = rand64();
		end
		w.kind = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_ADD;
		if ($urandom_range(0, 3) == 0) begin
			w.ip_high = rand64();
			w.ip_low  = rand64();
		end else begin
			w.ip_high = pool_hi[p];
			w.ip_low  = pool_lo[p];
		end
		link_bits      = rand64();
		w.link_address = link_bits[LINK_W-1:0];
		w.now_tick     = next_tick();
		return w;
	endfunction

	// Offer one request word after a random gap; return at the accepting edge
	task automatic send_word(input req_word_t w);
		int gap;
		if (send_quiet > 0) begin
			send_quiet--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, MAX_IDLE);
			if ($urandom_range(0, 15) == 0)
				send_quiet = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do @(posedge clk); while (!req_ch.ready);
		cache_sb.note_request(w);
	endtask

	// Drop valid and hold until every predicted word has been taken
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (cache_sb.pending() != 0);
	endtask

	// Response side: random stalls, quiet stretches and one long hold-off
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_quiet > 0) begin
				rsp_quiet--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_IDLE);
				if ($urandom_range(0, 15) == 0)
					rsp_quiet = $urandom_range(10, 40);
			end
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				stall = stall + HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			cache_sb.check_response(rsp_ch.data);
		end
	end

	// Reset, directed words, random words, end of run
	initial begin
		cache_sb     = new();
		hold_rsp_req = 1'b0;
		send_quiet   = 0;
		rsp_quiet    = 0;
		tick_clock   = $urandom_range(1, 100);
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			// some pool entries share one half with their neighbor
			pool_hi[i] = (i % 3 == 2) ? pool_hi[i-1] : rand64();
			pool_lo[i] = (i % 4 == 1) ? pool_lo[i-1] : rand64();
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty cache: lookup misses even for the all-zero address
		send_word(make_word(KIND_LOOKUP, '0, '0, '1, TICK_MAX));
		// Zero tick is stamped as one and still counts as valid
		send_word(make_word(KIND_ADD, '0, '0, '0, TICK_FREE));
		send_word(make_word(KIND_LOOKUP, '0, '0, '1, '0));
		send_word(make_word(KIND_ADD, '1, '1, '1, TICK_MAX));
		send_word(make_word(KIND_LOOKUP, '1, '1, '0, TICK_MAX));
		// Refresh an existing address
		send_word(make_word(KIND_ADD, '0, '0, 48'h5A5A_A5A5_0F0F, TICK_MAX));
		// Addresses that match in one half only
		send_word(make_word(KIND_ADD, '1, '0, 48'h0000_0000_0001, TICK_MAX));
		send_word(make_word(KIND_ADD, '0, '1, 48'h8000_0000_0000, TICK_MAX));
		send_word(make_word(KIND_LOOKUP, '1, '0, '0, '0));
		send_word(make_word(KIND_LOOKUP, '0, '1, '0, '0));
		send_word(make_word(KIND_LOOKUP, '1, 64'd1, '0, '0));
		// Fill the cache with every tick at the maximum
		for (int i = 0; i < 4; i++)
			send_word(make_word(KIND_ADD, 64'hC0DE_0000_0000_0000 + i, 64'(i),
			                    48'(i + 1), TICK_MAX));
		// All ticks at the maximum: entry zero is replaced
		send_word(make_word(KIND_ADD, 64'hBEEF, 64'hF00D, 48'hFFFF_0000_FFFF, TICK_MAX));
		send_word(make_word(KIND_LOOKUP, '0, '0, '0, '0));
		send_word(make_word(KIND_LOOKUP, 64'hBEEF, 64'hF00D, '0, '0));
		// Small ticks, one of them repeated: the smallest one goes first, lowest index on ties
		send_word(make_word(KIND_ADD, 64'h1111, 64'h1, 48'h1, 32'd7));
		send_word(make_word(KIND_ADD, 64'h2222, 64'h2, 48'h2, 32'd7));
		send_word(make_word(KIND_ADD, 64'h3333, 64'h3, 48'h3, 32'd3));
		send_word(make_word(KIND_ADD, 64'h4444, 64'h4, 48'h4, 32'd9));
		send_word(make_word(KIND_LOOKUP, 64'h1111, 64'h1, '0, '0));
		send_word(make_word(KIND_LOOKUP, 64'h3333, 64'h3, '0, '0));

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) begin
				// long response hold-off while words keep coming
				hold_rsp_req = 1'b1;
				send_quiet   = 30;
			end
			if (n == 800)
				wait_drained();
			send_word(random_word());
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (cache_sb.errors == 0 && cache_sb.pending() == 0)
			$display("neighbor_cache_oldest_replace regression: pass");
		else
			$display("neighbor_cache_oldest_replace regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
